FILE: hw/rtl/smf_pkg.sv
// Shared types and constants for the selective median filter.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package smf_pkg;

   localparam int MAX_RADIUS = 3;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int RING_ROWS  = 2 * MAX_RADIUS + 1;
   localparam int WIN_MAX    = RING_ROWS * RING_ROWS;
   localparam int EMIT_CAP   = MAX_RADIUS + 1;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
   localparam int RING_W     = $clog2(RING_ROWS);
   localparam int ADDR_W     = RING_W + COL_W;
   localparam int MEM_DEPTH  = RING_ROWS * MAX_WIDTH;

   localparam logic [7:0] CSR_RADIUS    = 8'd0;
   localparam logic [7:0] CSR_THRESHOLD = 8'd1;
   localparam logic [7:0] CSR_WIDTH     = 8'd2;
   localparam logic [7:0] CSR_HEIGHT    = 8'd3;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       frame_last;
   } rsp_word_type;

   typedef struct packed {
      logic clear;
      logic insert;
   } sort_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_FLUSH,
      ST_MEDIAN,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/smf_line_mem.sv
// Ring of line buffers holding packed RGB pixels, one write and one read port.
// Depends on smf_pkg for sizes.
`timescale 1ns / 1ps
`default_nettype none

module smf_line_mem
   import smf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [23:0]       wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [23:0]       rd_data
);

   logic [23:0] mem [MEM_DEPTH];
   logic [23:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/smf_cell.sv
// One cell of the insertion sorting chain: holds a value and takes its
// neighbor's value or the new word. Depends on smf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smf_cell
   import smf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire sort_ctl_type ctl,
   input  wire logic [7:0]   new_val,
   input  wire logic [7:0]   prev_val,
   input  wire logic         prev_valid,
   output logic      [7:0]   val,
   output logic              valid
);

   logic [7:0] val_ff, val_in;
   logic       valid_ff, valid_in;
   logic       keep, prev_le;

   always_comb begin
      keep     = valid_ff && (val_ff <= new_val);
      prev_le  = prev_valid && (prev_val <= new_val);
      val_in   = val_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.insert && !keep) begin
         if (prev_le) begin
            val_in   = new_val;
            valid_in = 1'b1;
         end else begin
            val_in   = prev_val;
            valid_in = prev_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      val_ff <= val_in;
   end

   assign val   = val_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/smf_sort_chain.sv
// Chain of sorting cells for one color channel, with the median tap select.
// Depends on smf_pkg and smf_cell.
`timescale 1ns / 1ps
`default_nettype none

module smf_sort_chain
   import smf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire sort_ctl_type ctl,
   input  wire logic [7:0]   new_val,
   input  wire logic [1:0]   radius,
   output logic      [7:0]   median
);

   logic [7:0] vals [WIN_MAX];
   logic       vlds [WIN_MAX];

   for (genvar i = 0; i < WIN_MAX; i++) begin : g_cell
      if (i == 0) begin : g_head
         smf_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .new_val    (new_val),
            .prev_val   (8'd0),
            .prev_valid (1'b1),
            .val        (vals[i]),
            .valid      (vlds[i])
         );
      end else begin : g_body
         smf_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .new_val    (new_val),
            .prev_val   (vals[i-1]),
            .prev_valid (vlds[i-1]),
            .val        (vals[i]),
            .valid      (vlds[i])
         );
      end
   end

   always_comb begin
      case (radius)
         2'd0:    median = vals[0];
         2'd1:    median = vals[4];
         2'd2:    median = vals[12];
         default: median = vals[24];
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/selective_median_filter_rgb.sv
// Top level of the selective median filter: control, counters and datapath.
// Depends on smf_pkg, smf_line_mem and smf_sort_chain.
//
// Usage: pixels enter on the req_ channel in raster order (op pixel), and
// drain words (op drain) flush the last rows once the frame is in. Each
// accepted word yields zero to four filtered pixels on the rsp_ channel,
// the last pixel of the frame carrying frame_last.
// The block handles one request word at a time: req_stall is low only
// while it is idle. Each emitted pixel is paced by the single read port
// of the line store feeding one window pixel per cycle into the sorting
// chains; for each emitted pixel a word steps through the check, read,
// flush, median and output states, the output state holding while the
// receiver stalls.
// Each result word sits in an output register until the receiver lowers
// rsp_stall; the block waits meanwhile.
// Reset clears the position counters and loads radius 3, threshold 40 and
// a 1024 by 1024 frame. Writes of radius, width or height restart the frame.
`timescale 1ns / 1ps
`default_nettype none

module selective_median_filter_rgb
   import smf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word,
   input  wire logic         csr_we,
   input  wire logic [7:0]   csr_index,
   input  wire logic [10:0]  csr_wdata
);

   state_type state_ff, state_in;

   logic [1:0]  rad_ff;
   logic [7:0]  thr_ff;
   logic [10:0] wid_ff, hgt_ff;
   logic [10:0] wid_e, hgt_e, wid_m1, hgt_m1;

   logic [COL_W-1:0]  in_col_ff, out_col_ff;
   logic [ROW_W-1:0]  in_row_ff, out_row_ff;
   logic [RING_W-1:0] in_ring_ff, out_ring_ff;
   logic [2:0]        emit_cnt_ff;
   logic signed [3:0] dy_ff, dx_ff;
   logic              v1_ff, cen_ff;
   logic [23:0]       center_ff;
   rsp_word_type      rsp_ff;

   logic [11:0] ny, nx;
   logic        ready, can_emit, last_tap, req_acc, rsp_acc, is_last_px, restart;
   logic        px_take, wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [23:0] rd_data;
   logic signed [12:0] yy;
   logic signed [11:0] xx, ydiff;
   logic signed [4:0]  ring_s;
   logic [10:0] y_cl;
   logic [COL_W-1:0] x_cl;
   logic [RING_W-1:0] rd_ring;
   logic signed [3:0] rad_s;
   sort_ctl_type ctl;
   logic [7:0] med_r, med_g, med_b;

   always_comb begin
      wid_e = (wid_ff == 11'd0) ? 11'd1 :
              (wid_ff > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : wid_ff;
      hgt_e = (hgt_ff == 11'd0) ? 11'd1 :
              (hgt_ff > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : hgt_ff;
      wid_m1 = wid_e - 11'd1;
      hgt_m1 = hgt_e - 11'd1;
      rad_s  = $signed({2'b00, rad_ff});
   end

   always_comb begin
      ny = {1'b0, out_row_ff} + {10'd0, rad_ff};
      if (ny > {1'b0, hgt_m1}) ny = {1'b0, hgt_m1};
      nx = {2'b00, out_col_ff} + {10'd0, rad_ff};
      if (nx > {1'b0, wid_m1}) nx = {1'b0, wid_m1};
      ready = ({1'b0, in_row_ff} > ny) ||
              (({1'b0, in_row_ff} == ny) && ({2'b00, in_col_ff} > nx));
      can_emit = (emit_cnt_ff < 3'(EMIT_CAP)) && (out_row_ff < hgt_e) &&
                 ({1'b0, out_col_ff} < wid_e) && ready;
      is_last_px = (out_row_ff == hgt_m1) && ({1'b0, out_col_ff} == wid_m1);
   end

   always_comb begin
      yy = $signed({2'b00, out_row_ff}) + 13'(dy_ff);
      if (yy < 0) begin
         y_cl = 11'd0;
      end else if (yy > $signed({2'b00, hgt_m1})) begin
         y_cl = hgt_m1;
      end else begin
         y_cl = yy[10:0];
      end
      ydiff  = $signed({1'b0, y_cl}) - $signed({1'b0, out_row_ff});
      ring_s = $signed({2'b00, out_ring_ff}) + 5'(ydiff);
      if (ring_s < 0) begin
         ring_s = ring_s + 5'(RING_ROWS);
      end else if (ring_s >= 5'(RING_ROWS)) begin
         ring_s = ring_s - 5'(RING_ROWS);
      end
      rd_ring = ring_s[RING_W-1:0];
      xx = $signed({2'b00, out_col_ff}) + 12'(dx_ff);
      if (xx < 0) begin
         x_cl = '0;
      end else if (xx > $signed({1'b0, wid_m1})) begin
         x_cl = wid_m1[COL_W-1:0];
      end else begin
         x_cl = xx[COL_W-1:0];
      end
      rd_addr  = {rd_ring, x_cl};
      last_tap = (dy_ff == rad_s) && (dx_ff == rad_s);
   end

   assign req_acc = (state_ff == ST_IDLE) && req_valid;
   assign rsp_acc = (state_ff == ST_OUT) && !rsp_stall;
   assign px_take = req_acc && (req_word.op == OP_PIXEL) && (in_row_ff < hgt_e);
   assign wr_en   = px_take;
   assign wr_addr = {in_ring_ff, in_col_ff};
   assign restart = csr_we && ((csr_index == CSR_RADIUS) || (csr_index == CSR_WIDTH) ||
                               (csr_index == CSR_HEIGHT));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_CHECK;
         ST_CHECK:  state_in = can_emit ? ST_READ : ST_IDLE;
         ST_READ:   if (last_tap) state_in = ST_FLUSH;
         ST_FLUSH:  state_in = ST_MEDIAN;
         ST_MEDIAN: state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_stall) state_in = is_last_px ? ST_IDLE : ST_CHECK;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      rsp_valid  = (state_ff == ST_OUT);
      ctl.clear  = (state_ff == ST_CHECK);
      ctl.insert = v1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rad_ff      <= 2'd3;
         thr_ff      <= 8'd40;
         wid_ff      <= 11'(MAX_WIDTH);
         hgt_ff      <= 11'(MAX_HEIGHT);
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_ring_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_ring_ff <= '0;
         emit_cnt_ff <= '0;
         dy_ff       <= '0;
         dx_ff       <= '0;
         v1_ff       <= 1'b0;
         cen_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= (state_ff == ST_READ);
         cen_ff   <= (state_ff == ST_READ) && (dy_ff == 4'sd0) && (dx_ff == 4'sd0);
         if (csr_we) begin
            case (csr_index)
               CSR_RADIUS:    rad_ff <= csr_wdata[1:0];
               CSR_THRESHOLD: thr_ff <= csr_wdata[7:0];
               CSR_WIDTH:     wid_ff <= csr_wdata;
               CSR_HEIGHT:    hgt_ff <= csr_wdata;
               default:       ;
            endcase
         end
         if (restart) begin
            in_col_ff   <= '0;
            in_row_ff   <= '0;
            in_ring_ff  <= '0;
            out_col_ff  <= '0;
            out_row_ff  <= '0;
            out_ring_ff <= '0;
         end else if (px_take) begin
            if (({1'b0, in_col_ff} + 11'd1) >= wid_e) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + 1'b1;
               in_ring_ff <= (in_ring_ff == RING_W'(RING_ROWS - 1)) ? '0 : in_ring_ff + 1'b1;
            end else begin
               in_col_ff <= in_col_ff + 1'b1;
            end
         end else if (rsp_acc) begin
            if (is_last_px) begin
               in_col_ff   <= '0;
               in_row_ff   <= '0;
               in_ring_ff  <= '0;
               out_col_ff  <= '0;
               out_row_ff  <= '0;
               out_ring_ff <= '0;
            end else if (({1'b0, out_col_ff} + 11'd1) >= wid_e) begin
               out_col_ff  <= '0;
               out_row_ff  <= out_row_ff + 1'b1;
               out_ring_ff <= (out_ring_ff == RING_W'(RING_ROWS - 1)) ? '0
                              : out_ring_ff + 1'b1;
            end else begin
               out_col_ff <= out_col_ff + 1'b1;
            end
         end
         if (req_acc) begin
            emit_cnt_ff <= '0;
         end else if (rsp_acc) begin
            emit_cnt_ff <= emit_cnt_ff + 1'b1;
         end
         if (state_ff == ST_CHECK) begin
            dy_ff <= -rad_s;
            dx_ff <= -rad_s;
         end else if (state_ff == ST_READ) begin
            if (dx_ff == rad_s) begin
               dx_ff <= -rad_s;
               dy_ff <= dy_ff + 4'sd1;
            end else begin
               dx_ff <= dx_ff + 4'sd1;
            end
         end
      end
   end

   function automatic logic [7:0] switch_chan(input logic [7:0] c, input logic [7:0] m,
                                              input logic [7:0] thr);
      logic [7:0] d;
      d = (c > m) ? c - m : m - c;
      return (d > thr) ? m : c;
   endfunction

   always_ff @(posedge clock) begin
      if (cen_ff) begin
         center_ff <= rd_data;
      end
      if (state_ff == ST_MEDIAN) begin
         rsp_ff.out_red    <= switch_chan(center_ff[23:16], med_r, thr_ff);
         rsp_ff.out_green  <= switch_chan(center_ff[15:8], med_g, thr_ff);
         rsp_ff.out_blue   <= switch_chan(center_ff[7:0], med_b, thr_ff);
         rsp_ff.frame_last <= is_last_px;
      end
   end

   assign rsp_word = rsp_ff;

   smf_line_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_word.in_red, req_word.in_green, req_word.in_blue}),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   smf_sort_chain u_chain_r (
      .clock (clock), .reset (reset), .ctl (ctl),
      .new_val (rd_data[23:16]), .radius (rad_ff), .median (med_r)
   );

   smf_sort_chain u_chain_g (
      .clock (clock), .reset (reset), .ctl (ctl),
      .new_val (rd_data[15:8]), .radius (rad_ff), .median (med_g)
   );

   smf_sort_chain u_chain_b (
      .clock (clock), .reset (reset), .ctl (ctl),
      .new_val (rd_data[7:0]), .radius (rad_ff), .median (med_b)
   );

endmodule

`default_nettype wire
